// ===== rtl/pic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

    localparam int NUM_SOURCES_DEF  = 32;
    localparam int NUM_CONTEXTS_DEF = 32;

    localparam logic [1:0] FUNC_READ   = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_SCAN   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [3:0]  ACCESS_WORD = 4'd4;
    localparam logic [21:0] PRIO_END    = 22'h001000;
    localparam logic [21:0] PEND_BASE   = 22'h001000;
    localparam logic [21:0] PEND_END    = 22'h001080;
    localparam logic [21:0] ENAB_BASE   = 22'h002000;
    localparam logic [21:0] ENAB_END    = 22'h1F2000;
    localparam logic [21:0] CTX_BASE    = 22'h200000;
    localparam logic [21:0] CTX_END     = 22'h300000;
    localparam logic [11:0] THR_OFF     = 12'h000;
    localparam logic [11:0] CLAIM_OFF   = 12'h004;

    typedef struct packed {
        logic [1:0]  func;
        logic [21:0] offset;
        logic [31:0] wdata;
        logic [3:0]  access_size;
        logic [3:0]  hart;
        logic        priv_machine;
        logic [31:0] source_pending;
    } pic_in_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        ok;
        logic        irq_set;
        logic        irq_clear;
        logic [4:0]  irq_context;
        logic [4:0]  cleared_source;
        logic        cleared_source_valid;
    } pic_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC,
        ST_SCAN,
        ST_FINISH
    } pic_state_t;

endpackage

`default_nettype wire

// ===== rtl/platform_interrupt_controller.sv =====
// A register read or write passes through the lookup and execute states, and its result is
// registered at the output. A scan of a context with no claim outstanding runs the scan
// state, one stored priority read per cycle, then the finish state. One transaction at a
// time: the next is accepted once the result is registered and the state is back to idle.
// Reset: synchronous, active low; all registers read as zero after reset through
// per-entry valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module platform_interrupt_controller
    import pic_pkg::*;
#(
    parameter int NUM_SOURCES  = NUM_SOURCES_DEF,
    parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire pic_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output pic_out_t      m_data
);

    localparam int SW = $clog2(NUM_SOURCES);
    localparam int CW = $clog2(NUM_CONTEXTS);
    localparam logic [NUM_SOURCES-1:0] SRC_MASK = {{(NUM_SOURCES-1){1'b1}}, 1'b0};
    localparam logic [SW-1:0] LAST_SRC = SW'(NUM_SOURCES - 1);

    // Memories, with a valid bit per entry standing in for the reset value.
    logic [31:0]            prio_mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] enab_mem [NUM_CONTEXTS];
    logic [31:0]            thr_mem  [NUM_CONTEXTS];
    logic [SW-1:0]          claim_mem[NUM_CONTEXTS];

    logic [NUM_SOURCES-1:0]  prio_vld_reg, prio_vld_next;
    logic [NUM_CONTEXTS-1:0] enab_vld_reg, enab_vld_next;
    logic [NUM_CONTEXTS-1:0] thr_vld_reg, thr_vld_next;
    logic [NUM_CONTEXTS-1:0] claim_vld_reg, claim_vld_next;

    logic [31:0]            prio_rd_reg;
    logic [NUM_SOURCES-1:0] enab_rd_reg;
    logic [31:0]            thr_rd_reg;
    logic [SW-1:0]          claim_rd_reg;
    logic                   prio_rv_reg, enab_rv_reg, thr_rv_reg, claim_rv_reg;

    pic_state_t             state_reg, state_next;
    pic_in_t                in_reg, in_next;
    logic [NUM_SOURCES-1:0] pend_reg, pend_next;
    logic [SW-1:0]          idx_reg, idx_next;
    logic                   issued_reg, issued_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [SW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [31:0]            best_reg, best_next;
    logic [SW-1:0]          sel_reg, sel_next;
    logic                   m_valid_reg, m_valid_next;
    pic_out_t               m_data_reg, m_data_next;

    // Memory port controls.
    logic          rd_en, prio_rd_en;
    logic [SW-1:0] prio_addr;
    logic [CW-1:0] ctx_addr;
    logic          prio_we, enab_we, thr_we, claim_we;
    logic [SW-1:0] claim_wdata;

    // Decode of the held transaction.
    logic [21:0]   off;
    logic [9:0]    src_w;
    logic [21:0]   enab_rel;
    logic [14:0]   enab_ctx;
    logic [7:0]    ctx_w;
    logic [11:0]   ctx_r;
    logic [4:0]    scan_ctx;
    logic          is_prio, is_pend, is_enab, is_ctx, is_wr, size_ok;
    logic          src_ok, enab_ok, ctx_ok, scan_ok;
    logic [31:0]   prio_eff, thr_eff;
    logic [NUM_SOURCES-1:0] enab_eff, req;
    logic [SW-1:0] claim_eff;
    logic          out_free;
    pic_out_t      res;

    assign off      = in_reg.offset;
    assign src_w    = off[11:2];
    assign enab_rel = off - ENAB_BASE;
    assign enab_ctx = enab_rel[21:7];
    assign ctx_w    = off[19:12];
    assign ctx_r    = off[11:0];
    assign scan_ctx = {in_reg.hart, ~in_reg.priv_machine};
    assign is_prio  = off < PRIO_END;
    assign is_pend  = (off >= PEND_BASE) && (off < PEND_END);
    assign is_enab  = (off >= ENAB_BASE) && (off < ENAB_END);
    assign is_ctx   = (off >= CTX_BASE) && (off < CTX_END);
    assign is_wr    = in_reg.func == FUNC_WRITE;
    assign size_ok  = in_reg.access_size == ACCESS_WORD;
    assign src_ok   = 32'(src_w) < 32'(NUM_SOURCES);
    assign enab_ok  = (enab_rel[6:0] == 7'd0) && (32'(enab_ctx) < 32'(NUM_CONTEXTS));
    assign ctx_ok   = 32'(ctx_w) < 32'(NUM_CONTEXTS);
    assign scan_ok  = 32'(scan_ctx) < 32'(NUM_CONTEXTS);
    assign req      = in_reg.source_pending[NUM_SOURCES-1:0] & SRC_MASK;

    assign prio_eff  = prio_rv_reg ? prio_rd_reg : 32'd0;
    assign enab_eff  = enab_rv_reg ? enab_rd_reg : '0;
    assign thr_eff   = thr_rv_reg ? thr_rd_reg : 32'd0;
    assign claim_eff = claim_rv_reg ? claim_rd_reg : '0;
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        in_next        = in_reg;
        pend_next      = pend_reg;
        idx_next       = idx_reg;
        issued_next    = issued_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        best_next      = best_reg;
        sel_next       = sel_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        prio_vld_next  = prio_vld_reg;
        enab_vld_next  = enab_vld_reg;
        thr_vld_next   = thr_vld_reg;
        claim_vld_next = claim_vld_reg;
        rd_en          = 1'b0;
        prio_rd_en     = 1'b0;
        prio_addr      = src_w[SW-1:0];
        ctx_addr       = (in_reg.func == FUNC_SCAN) ? scan_ctx[CW-1:0]
                       : is_enab ? enab_ctx[CW-1:0] : ctx_w[CW-1:0];
        prio_we        = 1'b0;
        enab_we        = 1'b0;
        thr_we         = 1'b0;
        claim_we       = 1'b0;
        claim_wdata    = '0;
        res            = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                rd_en      = 1'b1;
                prio_rd_en = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (in_reg.func == FUNC_SCAN && scan_ok && claim_eff == '0) begin
                    best_next   = thr_eff;
                    sel_next    = '0;
                    idx_next    = SW'(1);
                    issued_next = 1'b0;
                    state_next  = ST_SCAN;
                end else if (out_free) begin
                    if ((in_reg.func == FUNC_READ || is_wr) && size_ok) begin
                        if (is_prio) begin
                            res.ok = 1'b1;
                            if (src_ok) begin
                                if (is_wr) begin
                                    prio_we = 1'b1;
                                    prio_vld_next[src_w[SW-1:0]] = 1'b1;
                                end else begin
                                    res.rdata = prio_eff;
                                end
                            end
                        end else if (is_pend) begin
                            if (!is_wr) begin
                                res.ok = 1'b1;
                                if (off[6:2] == 5'd0) res.rdata = 32'(pend_reg);
                            end
                        end else if (is_enab) begin
                            res.ok = 1'b1;
                            if (enab_ok) begin
                                if (is_wr) begin
                                    enab_we = 1'b1;
                                    enab_vld_next[enab_ctx[CW-1:0]] = 1'b1;
                                end else begin
                                    res.rdata = 32'(enab_eff);
                                end
                            end
                        end else if (is_ctx) begin
                            if (!ctx_ok) begin
                                res.ok = !is_wr;
                            end else if (ctx_r == THR_OFF) begin
                                res.ok = 1'b1;
                                if (is_wr) begin
                                    thr_we = 1'b1;
                                    thr_vld_next[ctx_w[CW-1:0]] = 1'b1;
                                end else begin
                                    res.rdata = thr_eff;
                                end
                            end else if (ctx_r == CLAIM_OFF) begin
                                res.ok = 1'b1;
                                if (!is_wr) begin
                                    res.rdata = 32'(claim_eff);
                                end else if (32'(claim_eff) == in_reg.wdata) begin
                                    claim_we = 1'b1;
                                    claim_vld_next[ctx_w[CW-1:0]] = 1'b1;
                                    res.irq_clear   = 1'b1;
                                    res.irq_context = 5'(ctx_w);
                                end
                            end else begin
                                res.ok = !is_wr;
                            end
                        end
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = res;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // One priority read per cycle; the compare works on the registered read data.
                prio_addr = idx_reg;
                if (!issued_reg) begin
                    prio_rd_en   = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg;
                    if (idx_reg == LAST_SRC) issued_next = 1'b1;
                    else idx_next = idx_reg + SW'(1);
                end
                if (cmp_vld_reg) begin
                    if (req[cmp_idx_reg] && enab_eff[cmp_idx_reg] && prio_eff >= best_reg) begin
                        best_next = prio_eff;
                        sel_next  = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == LAST_SRC) state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    pend_next = pend_reg | req;
                    if (sel_reg != '0) begin
                        pend_next[sel_reg] = 1'b0;
                        claim_we       = 1'b1;
                        claim_wdata    = sel_reg;
                        claim_vld_next[scan_ctx[CW-1:0]] = 1'b1;
                        res.irq_set              = 1'b1;
                        res.irq_context          = scan_ctx;
                        res.cleared_source       = 5'(sel_reg);
                        res.cleared_source_valid = 1'b1;
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = res;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Reads and writes never share a cycle, so no forwarding is needed.
    always_ff @(posedge aclk) begin
        if (prio_we) prio_mem[prio_addr] <= in_reg.wdata;
        if (enab_we) enab_mem[ctx_addr] <= in_reg.wdata[NUM_SOURCES-1:0];
        if (thr_we) thr_mem[ctx_addr] <= in_reg.wdata;
        if (claim_we) claim_mem[ctx_addr] <= claim_wdata;
        if (prio_rd_en) begin
            prio_rd_reg <= prio_mem[prio_addr];
            prio_rv_reg <= prio_vld_reg[prio_addr];
        end
        if (rd_en) begin
            enab_rd_reg  <= enab_mem[ctx_addr];
            enab_rv_reg  <= enab_vld_reg[ctx_addr];
            thr_rd_reg   <= thr_mem[ctx_addr];
            thr_rv_reg   <= thr_vld_reg[ctx_addr];
            claim_rd_reg <= claim_mem[ctx_addr];
            claim_rv_reg <= claim_vld_reg[ctx_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_reg      <= '0;
            prio_vld_reg  <= '0;
            enab_vld_reg  <= '0;
            thr_vld_reg   <= '0;
            claim_vld_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            issued_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            prio_vld_reg  <= prio_vld_next;
            enab_vld_reg  <= enab_vld_next;
            thr_vld_reg   <= thr_vld_next;
            claim_vld_reg <= claim_vld_next;
            cmp_vld_reg   <= cmp_vld_next;
            issued_reg    <= issued_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg      <= in_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        best_reg    <= best_next;
        sel_reg     <= sel_next;
        m_data_reg  <= m_data_next;
    end

`ifndef SYNTHESIS
    a_accept_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ST_LOOKUP)
        else $error("accepted transaction did not start a lookup");

    a_set_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.irq_set) |->
            (m_data.cleared_source_valid && m_data.cleared_source != 5'd0 && !m_data.ok))
        else $error("interrupt raised without a valid cleared source");

    a_source_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !pend_reg[0])
        else $error("source zero latched as pending");

    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.irq_set && m_data.irq_clear))
        else $error("interrupt raised and dropped in one transaction");
`endif

endmodule

`default_nettype wire
